// File: src/lrf_pkg.sv
// Shared types and constants for the longest-remaining-first scheduler.
// Used by lrf_cmp and longest_remaining_first_scheduler; no dependencies.
`default_nettype none

package lrf_pkg;

  localparam int DATA_W  = 16;
  localparam int TIME_W  = 32;
  localparam int OSLOT_W = 3;

  // Function codes of an input item
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // One slot table entry
  typedef struct packed {
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] burst;
  } entry_t;

  // Control of the shared compare unit
  typedef struct packed {
    logic clear;
    logic en;
  } cmp_ctl_t;

endpackage

`default_nettype wire

// File: src/lrf_cmp.sv
// Shared compare unit: keeps the best candidate seen during a slot scan.
// Depends on lrf_pkg for entry_t and cmp_ctl_t.
`default_nettype none

module lrf_cmp import lrf_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmp_ctl_t                   ctl,
  input  logic [$clog2(SLOTS)-1:0]   cand_idx,
  input  entry_t                     cand,
  input  logic                       cand_ok,
  output logic                       found,
  output logic [$clog2(SLOTS)-1:0]   best_idx,
  output entry_t                     best
);

  logic better;

  // Candidate wins on more remaining time, then on lower id; equal keeps the earlier slot
  assign better = cand_ok &&
                  (!found || (cand.rem > best.rem) ||
                   ((cand.rem == best.rem) && (cand.id < best.id)));

  // Hold or replace the running best
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.en && better) begin
      found <= 1'b1;
    end
    if (!ctl.clear && ctl.en && better) begin
      best_idx <= cand_idx;
      best     <= cand;
    end
  end

endmodule

`default_nettype wire

// File: src/longest_remaining_first_scheduler.sv
// Top level of the longest-remaining-first scheduler: slot table, sequencer, result register.
// Depends on lrf_pkg and lrf_cmp.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------------------------
//   request | req_valid | req_stall | func, slot, job_id, burst
//   result  | rsp_valid | rsp_stall | idle, chosen_slot, chosen_id, tick_time,
//           |           |           | finished, completion_time, wait_time
//
// A load item is written straight from idle. A tick item must finish before the next item
// can be taken: the slot table has one read port and is scanned one slot a cycle.
// req_stall is high while a tick is in progress; a tick whose result cannot be
// registered because an earlier result is still stalled waits in its update step.
// Reset (rst, synchronous) clears all valid bits, the time counter and the sequencer.
`default_nettype none

module longest_remaining_first_scheduler import lrf_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                func,
  input  logic [OSLOT_W-1:0]  slot,
  input  logic [DATA_W-1:0]   job_id,
  input  logic [DATA_W-1:0]   burst,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic                idle,
  output logic [OSLOT_W-1:0]  chosen_slot,
  output logic [DATA_W-1:0]   chosen_id,
  output logic [TIME_W-1:0]   tick_time,
  output logic                finished,
  output logic [TIME_W-1:0]   completion_time,
  output logic [TIME_W-1:0]   wait_time
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD, S_WAIT} state_t;

  state_t               state;
  logic [CNT_W-1:0]     cnt;
  logic                 cmp_pend;
  logic [SLOT_W-1:0]    cmp_idx;
  logic [SLOTS-1:0]     slot_vld;
  logic [TIME_W-1:0]    current_time;
  logic [TIME_W-1:0]    time_next;

  entry_t               mem [SLOTS];
  entry_t               rd_data;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  entry_t               wr_data;

  logic                 req_acc;
  logic                 load_ok;
  logic                 out_free;
  cmp_ctl_t             cmp_ctl;
  logic                 best_found;
  logic [SLOT_W-1:0]    best_idx;
  entry_t               best;
  logic                 best_last;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign load_ok   = (32'(slot) < SLOTS);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rd_addr   = cnt[SLOT_W-1:0];
  assign best_last = (best.rem == DATA_W'(1));
  assign time_next = (current_time == '1) ? current_time : current_time + TIME_W'(1);

  // Table write: a load from idle, or the decremented entry from the update step
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = SLOT_W'(slot);
    wr_data = '{id: job_id, rem: burst, burst: burst};
    if (state == S_UPD) begin
      wr_en   = best_found && out_free;
      wr_addr = best_idx;
      wr_data = '{id: best.id, rem: best.rem - DATA_W'(1), burst: best.burst};
    end else if (req_acc && func == FUNC_LOAD) begin
      wr_en = load_ok;
    end
  end

  // Slot table with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign cmp_ctl.clear = req_acc && (func == FUNC_TICK);
  assign cmp_ctl.en    = (state == S_SCAN) && cmp_pend;

  lrf_cmp #(.SLOTS(SLOTS)) u_cmp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (cmp_ctl),
    .cand_idx (cmp_idx),
    .cand     (rd_data),
    .cand_ok  (slot_vld[cmp_idx] && (rd_data.rem != '0)),
    .found    (best_found),
    .best_idx (best_idx),
    .best     (best)
  );

  // Sequencer, valid bits, time counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      cmp_pend     <= 1'b0;
      slot_vld     <= '0;
      current_time <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (func == FUNC_TICK) begin
              state    <= S_SCAN;
              cnt      <= '0;
              cmp_pend <= 1'b0;
            end else if (load_ok) begin
              slot_vld[SLOT_W'(slot)] <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // issue one read a cycle; the compare takes the registered read data in the next cycle
          if (cnt < CNT_W'(SLOTS)) begin
            cmp_idx  <= rd_addr;
            cmp_pend <= 1'b1;
            cnt      <= cnt + CNT_W'(1);
          end else begin
            cmp_pend <= 1'b0;
            state    <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            tick_time <= current_time;
            wait_time <= '0;
            if (best_found) begin
              idle        <= 1'b0;
              chosen_slot <= OSLOT_W'(best_idx);
              chosen_id   <= best.id;
              finished    <= best_last;
              completion_time <= best_last ? time_next : '0;
              current_time    <= time_next;
              if (best_last) begin
                slot_vld[best_idx] <= 1'b0;
              end
            end else begin
              idle            <= 1'b1;
              chosen_slot     <= '0;
              chosen_id       <= '0;
              finished        <= 1'b0;
              completion_time <= '0;
            end
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // waiting time from completion time, floored at zero
          if (finished && completion_time >= TIME_W'(best.burst)) begin
            wait_time <= completion_time - TIME_W'(best.burst);
          end
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_longest_remaining_first_scheduler.sv
// Self-checking testbench for the longest-remaining-first scheduler.
// Needs lrf_pkg and longest_remaining_first_scheduler; drives directed rows, then random job
// batches across several idling phases, and checks every result against its own slot model.
`timescale 1ns / 1ps

module tb_longest_remaining_first_scheduler;
  import lrf_pkg::*;

  localparam int NSLOTS       = 8;
  localparam int ITEM_TARGET  = 1350;
  localparam int HOLDOFF_LEN  = 300;
  localparam int SETTLE_LEN   = 24;
  localparam int WATCHDOG_MAX = 4000;

  // One tick result as the block presents it
  typedef struct packed {
    logic               idle;
    logic [OSLOT_W-1:0] slot;
    logic [DATA_W-1:0]  id;
    logic [TIME_W-1:0]  tick_time;
    logic               finished;
    logic [TIME_W-1:0]  done_at;
    logic [TIME_W-1:0]  waited;
  } tick_result_t;

  // One row of the directed stimulus; typed rows carry their result
  typedef struct {
    logic               func;
    logic [OSLOT_W-1:0] slot;
    logic [DATA_W-1:0]  id;
    logic [DATA_W-1:0]  burst;
    bit                 typed;
    tick_result_t       want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               func = FUNC_LOAD;
  logic [OSLOT_W-1:0] slot = '0;
  logic [DATA_W-1:0]  job_id = '0;
  logic [DATA_W-1:0]  burst = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic               idle;
  logic [OSLOT_W-1:0] chosen_slot;
  logic [DATA_W-1:0]  chosen_id;
  logic [TIME_W-1:0]  tick_time;
  logic               finished;
  logic [TIME_W-1:0]  completion_time;
  logic [TIME_W-1:0]  wait_time;

  // Shadow copy of the slot table
  logic [DATA_W-1:0] job_rem   [NSLOTS];
  logic [DATA_W-1:0] job_burst [NSLOTS];
  logic [DATA_W-1:0] job_ident [NSLOTS];
  bit                job_live  [NSLOTS];
  logic [TIME_W-1:0] sched_now;

  tick_result_t pending_ticks [$];
  dir_row_t     dir_rows [$];

  int send_pct = 0;
  int recv_pct = 0;
  int holdoff_reqs = 0;
  int holdoff_done = 0;
  int holdoff_cnt = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int n_items = 0, n_loads = 0, n_ticks = 0;
  int n_results = 0, n_finished = 0, n_idle = 0;

  longest_remaining_first_scheduler #(.SLOTS(NSLOTS)) DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .func(func), .slot(slot), .job_id(job_id), .burst(burst),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .idle(idle), .chosen_slot(chosen_slot), .chosen_id(chosen_id),
    .tick_time(tick_time), .finished(finished),
    .completion_time(completion_time), .wait_time(wait_time)
  );

  always #4 clk = ~clk;

  // Update the slot table for one item and queue the tick result it yields
  task automatic schedule_item(input logic f, input logic [OSLOT_W-1:0] s,
                               input logic [DATA_W-1:0] i, input logic [DATA_W-1:0] b);
    int best;
    tick_result_t r;
    best = -1;
    r = '0;
    if (f == FUNC_LOAD) begin
      job_ident[s] = i;
      job_rem[s]   = b;
      job_burst[s] = b;
      job_live[s]  = 1'b1;
      n_loads++;
    end else begin
      n_ticks++;
      for (int k = 0; k < NSLOTS; k++) begin
        if (job_live[k] && job_rem[k] != 0) begin
          if (best < 0 || job_rem[k] > job_rem[best] ||
              (job_rem[k] == job_rem[best] && job_ident[k] < job_ident[best]))
            best = k;
        end
      end
      r.tick_time = sched_now;
      if (best < 0) begin
        r.idle = 1'b1;
        n_idle++;
      end else begin
        job_rem[best] = job_rem[best] - 1'b1;
        if (sched_now != '1) sched_now = sched_now + 1'b1;
        r.slot = OSLOT_W'(best);
        r.id   = job_ident[best];
        if (job_rem[best] == 0) begin
          r.finished = 1'b1;
          r.done_at  = sched_now;
          r.waited   = (sched_now >= TIME_W'(job_burst[best])) ?
                       sched_now - TIME_W'(job_burst[best]) : '0;
          job_live[best] = 1'b0;
          n_finished++;
        end
      end
      pending_ticks.push_back(r);
    end
  endtask

  function automatic int work_left();
    int sum;
    sum = 0;
    for (int k = 0; k < NSLOTS; k++)
      if (job_live[k]) sum += int'(job_rem[k]);
    return sum;
  endfunction

  // Offer one item, with random gaps in front, and hold it until taken
  task automatic send_item(input logic f, input logic [OSLOT_W-1:0] s,
                           input logic [DATA_W-1:0] i, input logic [DATA_W-1:0] b);
    while ($urandom_range(0, 99) < send_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    func      <= f;
    slot      <= s;
    job_id    <= i;
    burst     <= b;
    do @(posedge clk); while (req_stall);
    schedule_item(f, s, i, b);
    n_items++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(input logic f, input int s, input int i, input int b);
    dir_row_t row;
    row.func  = f;
    row.slot  = OSLOT_W'(s);
    row.id    = DATA_W'(i);
    row.burst = DATA_W'(b);
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  // Typed row: a tick with no work at time zero
  function automatic void add_idle_row();
    add_row(FUNC_TICK, 0, 0, 0);
    dir_rows[$].typed = 1'b1;
    dir_rows[$].want.idle = 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Check one accepted result against the oldest expectation
  task automatic check_result();
    tick_result_t w;
    if (pending_ticks.size() == 0) begin
      $display("%0t: result with nothing expected: expected none, actual slot %0d id %0h",
               $time, chosen_slot, chosen_id);
      errors++;
    end else begin
      w = pending_ticks.pop_front();
      n_results++;
      check_field("idle", TIME_W'(w.idle), TIME_W'(idle));
      check_field("chosen_slot", TIME_W'(w.slot), TIME_W'(chosen_slot));
      check_field("chosen_id", TIME_W'(w.id), TIME_W'(chosen_id));
      check_field("tick_time", w.tick_time, tick_time);
      check_field("finished", TIME_W'(w.finished), TIME_W'(finished));
      check_field("completion_time", w.done_at, completion_time);
      check_field("wait_time", w.waited, wait_time);
    end
  endtask

  // Take results and drive the receiver's stall, long hold-offs included
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) check_result();
      if (holdoff_cnt > 0) begin
        holdoff_cnt--;
        rsp_stall <= 1'b1;
      end else if (holdoff_reqs != holdoff_done) begin
        holdoff_done++;
        holdoff_cnt = HOLDOFF_LEN;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || rst)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("[longest_remaining_first_scheduler] ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Load a handful of jobs, then up to 80 ticks for the work left; stray loads mixed in
  task automatic run_batch();
    int nl, nt, s;
    logic [DATA_W-1:0] idv, b;
    nl = $urandom_range(1, NSLOTS);
    for (int k = 0; k < nl; k++) begin
      s   = $urandom_range(0, NSLOTS - 1);
      idv = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 3)) : DATA_W'($urandom);
      case ($urandom_range(0, 31))
        0:       b = '0;
        1, 2:    b = DATA_W'($urandom);
        default: b = DATA_W'($urandom_range(1, 12));
      endcase
      send_item(FUNC_LOAD, OSLOT_W'(s), idv, b);
      // cut a long job short so it cannot starve the rest
      if (b > 64)
        send_item(FUNC_LOAD, OSLOT_W'(s), idv, DATA_W'($urandom_range(0, 12)));
    end
    nt = work_left() + $urandom_range(0, 2);
    if (nt > 80) nt = 80;
    for (int k = 0; k < nt; k++) begin
      if ($urandom_range(0, 11) == 0)
        send_item(FUNC_LOAD, OSLOT_W'($urandom), DATA_W'($urandom),
                  DATA_W'($urandom_range(0, 12)));
      send_item(FUNC_TICK, OSLOT_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
    end
  endtask

  initial begin
    for (int k = 0; k < NSLOTS; k++) begin
      job_rem[k]   = '0;
      job_burst[k] = '0;
      job_ident[k] = '0;
      job_live[k]  = 1'b0;
    end
    sched_now = '0;

    // Directed rows: empty table, zero burst, ties, extremes, overwrite of a running job
    add_idle_row();
    add_row(FUNC_LOAD, 0, 5, 0);
    add_idle_row();
    add_row(FUNC_LOAD, 7, 16'hFFFF, 2);
    add_row(FUNC_LOAD, 3, 16'h0000, 2);
    repeat (5) add_row(FUNC_TICK, 0, 0, 0);
    add_row(FUNC_LOAD, 1, 16'h1234, 16'hFFFF);
    add_row(FUNC_TICK, 7, 16'hFFFF, 16'hFFFF);
    add_row(FUNC_LOAD, 1, 16'h1234, 1);
    add_row(FUNC_LOAD, 2, 16'h1234, 1);
    repeat (3) add_row(FUNC_TICK, 0, 0, 0);
    add_row(FUNC_LOAD, 4, 16'h00FF, 3);
    add_row(FUNC_LOAD, 5, 16'hFF00, 3);
    add_row(FUNC_LOAD, 6, 16'h8000, 16'h8000);
    add_row(FUNC_LOAD, 6, 16'h8000, 0);
    repeat (4) add_row(FUNC_TICK, 0, 0, 0);

    // Hold reset, then release it on a clock edge
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].func, dir_rows[r].slot, dir_rows[r].id, dir_rows[r].burst);
      if (dir_rows[r].typed) pending_ticks[$] = dir_rows[r].want;
    end

    // Random batches over four idling phases; drain between phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_pct = 0;  recv_pct = 0;  end
        1:       begin send_pct = 52; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 52; end
        default: begin send_pct = 18; recv_pct = 18; end
      endcase
      // long receiver hold-off while items keep coming, so the block backs up
      if (phase == 0 || phase == 3) holdoff_reqs++;
      while (n_items < (phase + 1) * ITEM_TARGET / 4) run_batch();
      drain();
    end

    drain();
    repeat (SETTLE_LEN) @(posedge clk);
    if (pending_ticks.size() != 0) begin
      $display("%0t: %0d results never arrived: expected none left, actual %0d",
               $time, pending_ticks.size(), pending_ticks.size());
      errors++;
    end
    $display("Sent %0d items (%0d loads, %0d ticks); checked %0d results,",
             n_items, n_loads, n_ticks, n_results);
    $display("of which %0d completed a job and %0d found no work; %0d mismatches.",
             n_finished, n_idle, errors);
    if (errors == 0)
      $display("[longest_remaining_first_scheduler] OK");
    else
      $display("[longest_remaining_first_scheduler] ERROR");
    $finish;
  end

endmodule

// File: longest_remaining_first_scheduler.f
src/lrf_pkg.sv
src/lrf_cmp.sv
src/longest_remaining_first_scheduler.sv
tb/tb_longest_remaining_first_scheduler.sv
